>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked concurrent assertions used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/cthht_pkg.sv
// ----------------------------------------------------------------------------
// cthht_pkg
// Shared sizes and types of the cut-through head hold table.
// ----------------------------------------------------------------------------
package cthht_pkg;

  localparam int unsigned TABLE_ENTRIES = 8;
  localparam int unsigned ID_WIDTH      = 16;
  localparam int unsigned COUNT_WIDTH   = 8;

  typedef logic [TABLE_ENTRIES-1:0] ent_vec_t;
  typedef logic [ID_WIDTH-1:0]      id_t;
  typedef logic [COUNT_WIDTH-1:0]   count_t;

  // Output register occupancy
  typedef enum logic {
    ST_EMPTY,
    ST_HOLD
  } ctrl_state_e;

  // Command from controller to datapath
  typedef struct packed {
    logic load;     // take the flit: update the table and capture the verdict
  } cthht_cmd_t;

endpackage

>>> rtl/core/cthht_flit_if.sv
// ----------------------------------------------------------------------------
// cthht_flit_if
// Valid/ready channel carrying one flit descriptor per transaction.
// ----------------------------------------------------------------------------
interface cthht_flit_if import cthht_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   is_head;
  logic   head_blocked;
  id_t    head_id;
  count_t body_count;

  modport source (output valid, is_head, head_blocked, head_id, body_count, input ready);
  modport sink   (input valid, is_head, head_blocked, head_id, body_count, output ready);
endinterface

>>> rtl/core/cthht_res_if.sv
// ----------------------------------------------------------------------------
// cthht_res_if
// Valid/ready channel carrying one routing verdict per transaction.
// ----------------------------------------------------------------------------
interface cthht_res_if ();
  logic valid;
  logic ready;
  logic can_route;
  logic head_released;
  logic table_overflow;

  modport source (output valid, can_route, head_released, table_overflow, input ready);
  modport sink   (input valid, can_route, head_released, table_overflow, output ready);
endinterface

>>> rtl/core/cthht_ctrl.sv
// ----------------------------------------------------------------------------
// cthht_ctrl
// Handshake controller: tracks the output register and issues load commands.
// ----------------------------------------------------------------------------
module cthht_ctrl import cthht_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output cthht_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o.load  = 1'b0;
    case (state_q)
      ST_EMPTY: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_HOLD;
        end
      end
      ST_HOLD: begin
        out_valid_o = 1'b1;
        // the held verdict leaves this cycle, so the register can refill
        in_ready_o  = out_ready_i;
        if (out_ready_i) begin
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
          end else begin
            state_d = ST_EMPTY;
          end
        end
      end
      default: begin
        state_d = ST_EMPTY;
      end
    endcase
  end

endmodule

>>> rtl/core/cthht_dp.sv
// ----------------------------------------------------------------------------
// cthht_dp
// Hold table with parallel id match, free slot pick and verdict register.
// ----------------------------------------------------------------------------
module cthht_dp import cthht_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cthht_cmd_t cmd_i,
  input  logic       is_head_i,
  input  logic       head_blocked_i,
  input  id_t        head_id_i,
  input  count_t     body_count_i,
  output logic       can_route_o,
  output logic       head_released_o,
  output logic       table_overflow_o
);

  ent_vec_t entry_valid_q, entry_valid_d;
  id_t      entry_head_q [TABLE_ENTRIES];
  count_t   entry_rem_q  [TABLE_ENTRIES];

  ent_vec_t hit_vec, hit_oh, free_vec, free_oh, wr_oh;
  logic     any_hit, any_free;
  count_t   hit_rem;
  logic     dec_en;
  logic     route_d, released_d, overflow_d;
  logic     can_route_q, head_released_q, table_overflow_q;

  always_comb begin
    hit_rem = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_vec[i] = entry_valid_q[i] && (entry_head_q[i] == head_id_i);
    end
    free_vec = ~entry_valid_q;
    // isolate the lowest set bit
    hit_oh   = hit_vec & (~hit_vec + TABLE_ENTRIES'(1));
    free_oh  = free_vec & (~free_vec + TABLE_ENTRIES'(1));
    any_hit  = |hit_vec;
    any_free = |free_vec;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit_oh[i]) begin
        hit_rem = hit_rem | entry_rem_q[i];
      end
    end
  end

  always_comb begin
    entry_valid_d = entry_valid_q;
    wr_oh         = '0;
    dec_en        = 1'b0;
    route_d       = 1'b1;
    released_d    = 1'b0;
    overflow_d    = 1'b0;
    if (is_head_i) begin
      if (head_blocked_i) begin
        route_d = 1'b0;
        if (any_hit) begin
          wr_oh = hit_oh;
        end else if (any_free) begin
          wr_oh = free_oh;
        end else begin
          overflow_d = 1'b1;
        end
        entry_valid_d = entry_valid_q | wr_oh;
      end
    end else if (any_hit) begin
      if (hit_rem > COUNT_WIDTH'(1)) begin
        dec_en  = 1'b1;
        route_d = 1'b0;
      end else begin
        // last body flit: free the entry
        entry_valid_d = entry_valid_q & ~hit_oh;
        released_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
    end else if (cmd_i.load) begin
      entry_valid_q <= entry_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (cmd_i.load && wr_oh[i]) begin
        entry_head_q[i] <= head_id_i;
        entry_rem_q[i]  <= body_count_i;
      end else if (cmd_i.load && dec_en && hit_oh[i]) begin
        entry_rem_q[i]  <= hit_rem - COUNT_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      can_route_q      <= route_d;
      head_released_q  <= released_d;
      table_overflow_q <= overflow_d;
    end
  end

  assign can_route_o      = can_route_q;
  assign head_released_o  = head_released_q;
  assign table_overflow_o = table_overflow_q;

endmodule

>>> rtl/core/cut_through_head_hold_table.sv
// ----------------------------------------------------------------------------
// cut_through_head_hold_table
// Routing gate for cut-through flits backed by a table of blocked heads.
//
// Each flit gets one verdict: may it route now, did it free its head's entry,
// did a blocked head overflow the table. A blocked head stores or refreshes
// an entry with its body count; matching body flits count it down and free
// it on the last one. The table is cleared by reset, with no sweep. The block
// takes one flit per clock cycle while the consumer is ready: a flit is judged
// in the cycle it is taken, and its verdict appears from the output register
// in the next cycle, while the next flit can already be taken if the consumer
// is ready. The critical path is the parallel compare of the flit id against
// all table entries followed by the lowest-slot pick.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cut_through_head_hold_table import cthht_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  cthht_flit_if.sink  flit_i,
  cthht_res_if.source res_o
);

  cthht_cmd_t cmd;
  logic       out_valid;

  cthht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (flit_i.valid),
    .in_ready_o  (flit_i.ready),
    .out_valid_o (out_valid),
    .out_ready_i (res_o.ready),
    .cmd_o       (cmd)
  );

  cthht_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .is_head_i        (flit_i.is_head),
    .head_blocked_i   (flit_i.head_blocked),
    .head_id_i        (flit_i.head_id),
    .body_count_i     (flit_i.body_count),
    .can_route_o      (res_o.can_route),
    .head_released_o  (res_o.head_released),
    .table_overflow_o (res_o.table_overflow)
  );

  assign res_o.valid = out_valid;

  `ASSERT_CLK(a_load_gives_verdict, clk_i, rst_ni, cmd.load |=> res_o.valid, "no verdict after transaction")
  `ASSERT_CLK(a_release_routes, clk_i, rst_ni, (res_o.valid && res_o.head_released) |-> res_o.can_route, "released flit held")
  `ASSERT_CLK(a_overflow_holds, clk_i, rst_ni, (res_o.valid && res_o.table_overflow) |-> (!res_o.can_route && !res_o.head_released), "overflow verdict inconsistent")
  `ASSERT_ALWAYS(a_load_needs_accept, clk_i, cmd.load |-> (flit_i.valid && flit_i.ready), "load without transaction")

endmodule
